>>> hw/rtl/bfw_pkg.sv
// Shared request and result codes for the breadth-first edge-list walker.
`default_nettype none
package bfw_pkg;
    localparam logic [1:0] REQ_ADD_EDGE = 2'd0;
    localparam logic [1:0] REQ_START    = 2'd1;
    localparam logic [1:0] REQ_ADVANCE  = 2'd2;
    localparam logic [1:0] REQ_CLEAR    = 2'd3;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_CHILD  = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;

    localparam int PORT_NODE_W = 16;
    localparam int BLOCK_W     = 7;
    localparam int LEVEL_W     = 8;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

    typedef logic [LEVEL_W-1:0] level_t;
endpackage
`default_nettype wire

>>> hw/rtl/edge_list_breadth_first_walk.sv
// Add, start and clear requests complete in the idle state as they are accepted; an advance
// that ends the search emits a done record. An expanding advance scans every stored edge,
// and for each source match compares the child against the visited list until it is found
// or the list ends, then emits a header and the appended children, waiting on out_ready.
// Requests are taken one at a time, only while idle, as the walk steps through both memories.
// Asynchronous active-low reset clears counters, pointers and control; memories keep
// their contents, and only entries below their fill counts are used.
`default_nettype none
module edge_list_breadth_first_walk
    import bfw_pkg::*;
#(
    parameter int EDGE_CAP  = 1024,
    parameter int NODE_CAP  = 64,
    parameter int NODE_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  req_type,
    input  wire logic [15:0] edge_source,
    input  wire logic [15:0] edge_target,
    input  wire logic [15:0] start_node,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [6:0]       block_number,
    output logic [7:0]       level,
    output logic [15:0]      node_id,
    output logic             overflow,
    output logic             last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data
);
    localparam int EAW = $clog2(EDGE_CAP);
    localparam int ECW = $clog2(EDGE_CAP + 1);
    localparam int VAW = $clog2(NODE_CAP);
    localparam int VCW = $clog2(NODE_CAP + 1);
    localparam int NW  = NODE_BITS;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_NODE   = 4'd1;
    localparam logic [3:0] ST_EISSUE = 4'd2;
    localparam logic [3:0] ST_ECHECK = 4'd3;
    localparam logic [3:0] ST_SISSUE = 4'd4;
    localparam logic [3:0] ST_SCHECK = 4'd5;
    localparam logic [3:0] ST_HDR    = 4'd6;
    localparam logic [3:0] ST_CHLOAD = 4'd7;
    localparam logic [3:0] ST_CHEMIT = 4'd8;
    localparam logic [3:0] ST_DONE   = 4'd9;

    logic [3:0]     state_reg, state_next;
    level_t         limit_reg;
    logic [ECW-1:0] ecount_reg, ecount_next;
    logic [VCW-1:0] vcount_reg, vcount_next;
    logic [VCW-1:0] rptr_reg, rptr_next;
    logic [VCW-1:0] fend_reg, fend_next;
    level_t         lvl_reg, lvl_next;
    logic [VCW-1:0] blocks_reg, blocks_next;
    logic [ECW-1:0] k_reg, k_next;
    logic [VCW-1:0] j_reg, j_next;
    logic [VCW-1:0] base_reg, base_next;
    logic [VCW-1:0] optr_reg, optr_next;
    logic           ovf_reg, ovf_next;
    logic [NW-1:0]  node_reg, node_next;
    logic [NW-1:0]  child_reg, child_next;

    logic           ov_reg, ov_next;
    logic [1:0]     okind_reg, okind_next;
    logic [VCW-1:0] oblk_reg, oblk_next;
    level_t         olvl_reg, olvl_next;
    logic [NW-1:0]  onode_reg, onode_next;
    logic           oovf_reg, oovf_next;
    logic           olast_reg, olast_next;

    logic [NW+15:0] src_ext, dst_ext, start_ext;
    logic [NW-1:0]  src_n, dst_n, start_n;
    logic [NW+15:0] onode_ext;

    logic           e_wr;
    logic [NW-1:0]  e_rd_src, e_rd_dst;
    logic           v_wr;
    logic [VAW-1:0] v_waddr, v_raddr;
    logic [NW-1:0]  v_wdata, v_rdata;

    logic           accept, slot_free;
    logic [VCW-1:0] adv_fend;
    level_t         adv_lvl;
    logic           adv_done;

    assign src_ext   = {NW'(0), edge_source};
    assign dst_ext   = {NW'(0), edge_target};
    assign start_ext = {NW'(0), start_node};
    assign src_n     = src_ext[NW-1:0];
    assign dst_n     = dst_ext[NW-1:0];
    assign start_n   = start_ext[NW-1:0];

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign slot_free = !ov_reg || out_ready;

    assign e_wr = accept && (req_type == REQ_ADD_EDGE) && (ecount_reg < ECW'(EDGE_CAP));

    bfw_edge_store #(.DEPTH(EDGE_CAP), .NODE_W(NW)) u_edges (
        .clk       (clk),
        .wr_en     (e_wr),
        .wr_addr   (ecount_reg[EAW-1:0]),
        .wr_source (src_n),
        .wr_target (dst_n),
        .rd_addr   (k_reg[EAW-1:0]),
        .rd_source (e_rd_src),
        .rd_target (e_rd_dst)
    );

    bfw_visit_store #(.DEPTH(NODE_CAP), .NODE_W(NW)) u_visited (
        .clk     (clk),
        .wr_en   (v_wr),
        .wr_addr (v_waddr),
        .wr_data (v_wdata),
        .rd_addr (v_raddr),
        .rd_data (v_rdata)
    );

    // Frontier roll-over and end-of-search test seen by an advance request.
    always_comb
    begin
        adv_fend = fend_reg;
        adv_lvl  = lvl_reg;
        if ((vcount_reg != '0) && (rptr_reg == fend_reg))
        begin
            adv_fend = vcount_reg;
            if (lvl_reg < LEVEL_MAX)
            begin
                adv_lvl = lvl_reg + 1'b1;
            end
        end
        adv_done = (vcount_reg == '0) || (rptr_reg >= adv_fend) ||
                   (rptr_reg >= VCW'(NODE_CAP)) || (adv_lvl >= limit_reg);
    end

    always_comb
    begin
        state_next  = state_reg;
        ecount_next = ecount_reg;
        vcount_next = vcount_reg;
        rptr_next   = rptr_reg;
        fend_next   = fend_reg;
        lvl_next    = lvl_reg;
        blocks_next = blocks_reg;
        k_next      = k_reg;
        j_next      = j_reg;
        base_next   = base_reg;
        optr_next   = optr_reg;
        ovf_next    = ovf_reg;
        node_next   = node_reg;
        child_next  = child_reg;
        ov_next     = ov_reg && !out_ready;
        okind_next  = okind_reg;
        oblk_next   = oblk_reg;
        olvl_next   = olvl_reg;
        onode_next  = onode_reg;
        oovf_next   = oovf_reg;
        olast_next  = olast_reg;
        v_wr        = 1'b0;
        v_waddr     = vcount_reg[VAW-1:0];
        v_wdata     = child_reg;
        v_raddr     = rptr_reg[VAW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_type)
                        REQ_ADD_EDGE:
                        begin
                            if (e_wr)
                            begin
                                ecount_next = ecount_reg + 1'b1;
                            end
                        end
                        REQ_START:
                        begin
                            v_wr        = 1'b1;
                            v_waddr     = '0;
                            v_wdata     = start_n;
                            vcount_next = VCW'(1);
                            rptr_next   = '0;
                            fend_next   = VCW'(1);
                            lvl_next    = level_t'(1);
                            blocks_next = '0;
                        end
                        REQ_CLEAR:
                        begin
                            ecount_next = '0;
                        end
                        REQ_ADVANCE:
                        begin
                            fend_next = adv_fend;
                            lvl_next  = adv_lvl;
                            if (adv_done)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                // Visited read at rptr was issued this cycle.
                                rptr_next   = rptr_reg + 1'b1;
                                blocks_next = blocks_reg + 1'b1;
                                base_next   = vcount_reg;
                                ovf_next    = 1'b0;
                                k_next      = '0;
                                state_next  = ST_NODE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_NODE:
            begin
                node_next  = v_rdata;
                state_next = ST_EISSUE;
            end
            ST_EISSUE:
            begin
                if (k_reg < ecount_reg)
                begin
                    state_next = ST_ECHECK;
                end
                else
                begin
                    state_next = ST_HDR;
                end
            end
            ST_ECHECK:
            begin
                if (e_rd_src != node_reg)
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_EISSUE;
                end
                else
                begin
                    child_next = e_rd_dst;
                    j_next     = '0;
                    state_next = ST_SISSUE;
                end
            end
            ST_SISSUE:
            begin
                v_raddr = j_reg[VAW-1:0];
                if (j_reg < vcount_reg)
                begin
                    state_next = ST_SCHECK;
                end
                else
                begin
                    // Not seen: append, or flag the drop when the list is full.
                    if (vcount_reg >= VCW'(NODE_CAP))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        v_wr        = 1'b1;
                        vcount_next = vcount_reg + 1'b1;
                    end
                    k_next     = k_reg + 1'b1;
                    state_next = ST_EISSUE;
                end
            end
            ST_SCHECK:
            begin
                if (v_rdata == child_reg)
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_EISSUE;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_SISSUE;
                end
            end
            ST_HDR:
            begin
                v_raddr = base_reg[VAW-1:0];
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    okind_next = KIND_HEADER;
                    oblk_next  = blocks_reg;
                    olvl_next  = lvl_reg;
                    onode_next = node_reg;
                    oovf_next  = ovf_reg;
                    olast_next = (vcount_reg == base_reg);
                    optr_next  = base_reg;
                    state_next = (vcount_reg == base_reg) ? ST_IDLE : ST_CHLOAD;
                end
            end
            ST_CHLOAD:
            begin
                child_next = v_rdata;
                state_next = ST_CHEMIT;
            end
            ST_CHEMIT:
            begin
                v_raddr = VAW'(optr_reg + 1'b1);
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    okind_next = KIND_CHILD;
                    oblk_next  = blocks_reg;
                    olvl_next  = lvl_reg;
                    onode_next = child_reg;
                    oovf_next  = ovf_reg;
                    olast_next = (optr_reg + 1'b1 == vcount_reg);
                    optr_next  = optr_reg + 1'b1;
                    state_next = (optr_reg + 1'b1 == vcount_reg) ? ST_IDLE : ST_CHLOAD;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    okind_next = KIND_DONE;
                    oblk_next  = blocks_reg;
                    olvl_next  = lvl_reg;
                    onode_next = '0;
                    oovf_next  = 1'b0;
                    olast_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            limit_reg  <= LEVEL_MAX;
            ecount_reg <= '0;
            vcount_reg <= '0;
            rptr_reg   <= '0;
            fend_reg   <= '0;
            lvl_reg    <= '0;
            blocks_reg <= '0;
            k_reg      <= '0;
            j_reg      <= '0;
            base_reg   <= '0;
            optr_reg   <= '0;
            ovf_reg    <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            ecount_reg <= ecount_next;
            vcount_reg <= vcount_next;
            rptr_reg   <= rptr_next;
            fend_reg   <= fend_next;
            lvl_reg    <= lvl_next;
            blocks_reg <= blocks_next;
            k_reg      <= k_next;
            j_reg      <= j_next;
            base_reg   <= base_next;
            optr_reg   <= optr_next;
            ovf_reg    <= ovf_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg  <= node_next;
        child_reg <= child_next;
        okind_reg <= okind_next;
        oblk_reg  <= oblk_next;
        olvl_reg  <= olvl_next;
        onode_reg <= onode_next;
        oovf_reg  <= oovf_next;
        olast_reg <= olast_next;
    end

    assign onode_ext    = {16'd0, onode_reg};
    assign out_valid    = ov_reg;
    assign kind         = okind_reg;
    assign block_number = BLOCK_W'(oblk_reg);
    assign level        = olvl_reg;
    assign node_id      = onode_ext[PORT_NODE_W-1:0];
    assign overflow     = oovf_reg;
    assign last         = olast_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vcount_reg <= VCW'(NODE_CAP))
        else $error("visited count beyond capacity");
    a_frontier_order: assert property (@(posedge clk) disable iff (!rst_n)
        (rptr_reg <= fend_reg) && (fend_reg <= vcount_reg))
        else $error("read pointer or frontier end out of order");
    a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ecount_reg <= ECW'(EDGE_CAP))
        else $error("edge count beyond capacity");
    a_child_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHEMIT) |-> (optr_reg < vcount_reg) && (optr_reg >= base_reg))
        else $error("child output pointer outside appended range");
`endif
endmodule
`default_nettype wire

>>> hw/rtl/bfw_edge_store.sv
// Edge memory: one write port for appended edges, one registered read port.
`default_nettype none
module bfw_edge_store #(
    parameter int DEPTH  = 1024,
    parameter int NODE_W = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [NODE_W-1:0]        wr_source,
    input  wire logic [NODE_W-1:0]        wr_target,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [NODE_W-1:0]        rd_source,
    output logic      [NODE_W-1:0]        rd_target
);
    logic [2*NODE_W-1:0] mem [DEPTH];
    logic [2*NODE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_source, wr_target};
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_source = rd_data_reg[2*NODE_W-1:NODE_W];
    assign rd_target = rd_data_reg[NODE_W-1:0];
endmodule
`default_nettype wire

>>> hw/rtl/bfw_visit_store.sv
// Visited-node list memory with one write port and a registered read port.
`default_nettype none
module bfw_visit_store #(
    parameter int DEPTH  = 64,
    parameter int NODE_W = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [NODE_W-1:0]        wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [NODE_W-1:0]        rd_data
);
    logic [NODE_W-1:0] mem [DEPTH];
    logic [NODE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule
`default_nettype wire

>>> bench/tb_top.sv
// Self-checking testbench for the breadth-first edge-list walker.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import bfw_pkg::*;

    typedef struct {
        logic [1:0]  kind;
        logic [6:0]  blk;
        logic [7:0]  lvl;
        logic [15:0] node;
        logic        ovf;
        logic        last;
    } walk_rec_t;

    typedef struct {
        logic [1:0]  req;
        logic [15:0] src;
        logic [15:0] dst;
        logic [15:0] start;
        bit          fixed;
        walk_rec_t   want;
    } stim_row_t;

    localparam int EDGE_SLOTS = 1024;
    localparam int NODE_SLOTS = 64;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  req_type = REQ_ADD_EDGE;
    logic [15:0] edge_source = '0;
    logic [15:0] edge_target = '0;
    logic [15:0] start_node = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [6:0]  block_number;
    logic [7:0]  level;
    logic [15:0] node_id;
    logic        overflow;
    logic        last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;

    // Predictor state.
    logic [15:0] edge_src_mem [EDGE_SLOTS];
    logic [15:0] edge_dst_mem [EDGE_SLOTS];
    int          edge_fill;
    logic [15:0] visited_mem [NODE_SLOTS];
    int          visited_fill;
    int          walk_ptr;
    int          frontier_stop;
    int          depth;
    int          blocks_seen;
    int          depth_limit;

    walk_rec_t   step_out[$];
    walk_rec_t   expected_recs[$];
    stim_row_t   directed[$];
    int          errors = 0;
    int          items_sent = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;

    edge_list_breadth_first_walk u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
        .edge_source(edge_source), .edge_target(edge_target), .start_node(start_node),
        .out_valid(out_valid), .out_ready(out_ready), .kind(kind),
        .block_number(block_number), .level(level), .node_id(node_id),
        .overflow(overflow), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    initial
    begin
        #4_000_000;
        $display("tb_top failed");
        $finish;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic report(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    function automatic bit is_visited(input logic [15:0] n);
        for (int j = 0; j < visited_fill && j < NODE_SLOTS; j++)
        begin
            if (visited_mem[j] == n)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic walk_rec_t mk_rec(input logic [1:0] k, input int b, input int l,
                                         input logic [15:0] n, input bit o, input bit e);
        walk_rec_t r;
        r.kind = k;
        r.blk  = b[6:0];
        r.lvl  = l[7:0];
        r.node = n;
        r.ovf  = o;
        r.last = e;
        return r;
    endfunction

    // Computes the results of one request into step_out and updates the state.
    task automatic walk_model_step(input logic [1:0] r, input logic [15:0] a,
                                   input logic [15:0] b, input logic [15:0] s);
        logic [15:0] parent;
        bit          dropped;
        walk_rec_t   kids[$];
        step_out.delete();
        case (r)
            REQ_ADD_EDGE:
            begin
                if (edge_fill < EDGE_SLOTS)
                begin
                    edge_src_mem[edge_fill] = a;
                    edge_dst_mem[edge_fill] = b;
                    edge_fill++;
                end
            end
            REQ_START:
            begin
                visited_mem[0] = s;
                visited_fill = 1;
                walk_ptr = 0;
                frontier_stop = 1;
                depth = 1;
                blocks_seen = 0;
            end
            REQ_CLEAR:
                edge_fill = 0;
            default:
            begin
                if (visited_fill != 0 && walk_ptr == frontier_stop)
                begin
                    frontier_stop = visited_fill;
                    if (depth < LEVEL_MAX)
                        depth++;
                end
                if (visited_fill == 0 || walk_ptr >= frontier_stop ||
                    walk_ptr >= NODE_SLOTS || depth >= depth_limit)
                begin
                    step_out.push_back(mk_rec(KIND_DONE, blocks_seen, depth, '0, 0, 1));
                end
                else
                begin
                    parent = visited_mem[walk_ptr];
                    walk_ptr++;
                    blocks_seen++;
                    dropped = 1'b0;
                    for (int k = 0; k < edge_fill; k++)
                    begin
                        if (edge_src_mem[k] == parent && !is_visited(edge_dst_mem[k]))
                        begin
                            if (visited_fill >= NODE_SLOTS)
                                dropped = 1'b1;
                            else
                            begin
                                visited_mem[visited_fill++] = edge_dst_mem[k];
                                kids.push_back(mk_rec(KIND_CHILD, blocks_seen, depth,
                                                      edge_dst_mem[k], 0, 0));
                            end
                        end
                    end
                    step_out.push_back(mk_rec(KIND_HEADER, blocks_seen, depth, parent,
                                              dropped, kids.size() == 0));
                    foreach (kids[i])
                    begin
                        kids[i].ovf = dropped;
                        kids[i].last = (i == kids.size() - 1);
                        step_out.push_back(kids[i]);
                    end
                end
            end
        endcase
    endtask

    always @(negedge clk)
    begin
        walk_rec_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_recs.size() == 0)
                report("unexpected result kind", kind, 0);
            else
            begin
                w = expected_recs.pop_front();
                if (kind !== w.kind) report("kind", kind, w.kind);
                if (block_number !== w.blk) report("block_number", block_number, w.blk);
                if (level !== w.lvl) report("level", level, w.lvl);
                if (node_id !== w.node) report("node_id", node_id, w.node);
                if (overflow !== w.ovf) report("overflow", overflow, w.ovf);
                if (last !== w.last) report("last", last, w.last);
            end
        end
    end

    // Valid is left high after acceptance; the next request or a pause decides its value.
    task automatic send_req(input logic [1:0] r, input logic [15:0] a, input logic [15:0] b,
                            input logic [15:0] s, input bit fixed, input walk_rec_t want);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= r;
        edge_source <= a;
        edge_target <= b;
        start_node <= s;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        walk_model_step(r, a, b, s);
        if (fixed)
            expected_recs.push_back(want);
        else
            foreach (step_out[i])
                expected_recs.push_back(step_out[i]);
        items_sent++;
    endtask

    task automatic req(input logic [1:0] r, input logic [15:0] a, input logic [15:0] b,
                       input logic [15:0] s);
        send_req(r, a, b, s, 1'b0, mk_rec(KIND_DONE, 0, 0, '0, 0, 0));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_recs.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        depth_limit = v;
    endtask

    function automatic logic [15:0] pick_node(input int span);
        if ($urandom_range(9) == 0)
            return 16'($urandom);
        return 16'($urandom_range(span));
    endfunction

    // One load-start-walk sequence over a small random graph, with some noise mixed in.
    task automatic run_sequence();
        int span;
        span = $urandom_range(3, 15);
        if ($urandom_range(4) != 0)
            req(REQ_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
        repeat ($urandom_range(0, 14))
            req(REQ_ADD_EDGE, pick_node(span), pick_node(span), 16'($urandom));
        if ($urandom_range(5) == 0)
            req(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        req(REQ_START, 16'($urandom), 16'($urandom), pick_node(span));
        repeat ($urandom_range(1, 8))
        begin
            if ($urandom_range(7) == 0)
                req(REQ_ADD_EDGE, pick_node(span), pick_node(span), 16'($urandom));
            req(REQ_ADVANCE, 16'($urandom), 16'($urandom), 16'($urandom));
        end
        if ($urandom_range(7) == 0)
            wait_drained();
    endtask

    function automatic stim_row_t row(input logic [1:0] r, input logic [15:0] a,
                                      input logic [15:0] b, input logic [15:0] s);
        stim_row_t t;
        t.req = r;
        t.src = a;
        t.dst = b;
        t.start = s;
        t.fixed = 1'b0;
        t.want = mk_rec(KIND_DONE, 0, 0, '0, 0, 0);
        return t;
    endfunction

    function automatic stim_row_t checked_row(input logic [1:0] r, input logic [15:0] s,
                                              input walk_rec_t w);
        stim_row_t t;
        t = row(r, '0, '0, s);
        t.fixed = 1'b1;
        t.want = w;
        return t;
    endfunction

    initial
    begin
        int limits[4];
        int target;
        edge_fill = 0;
        visited_fill = 0;
        walk_ptr = 0;
        frontier_stop = 0;
        depth = 0;
        blocks_seen = 0;
        depth_limit = 255;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Advance before any search, edge extremes, duplicates, loops and a cleared store.
        directed.push_back(checked_row(REQ_ADVANCE, '0, mk_rec(KIND_DONE, 0, 0, '0, 0, 1)));
        directed.push_back(row(REQ_ADD_EDGE, 16'hFFFF, 16'h0000, 16'h0000));
        directed.push_back(row(REQ_ADD_EDGE, 16'h0000, 16'hFFFF, 16'hFFFF));
        directed.push_back(row(REQ_ADD_EDGE, 16'h0000, 16'h0001, 16'h0000));
        directed.push_back(row(REQ_ADD_EDGE, 16'h0001, 16'h0002, 16'h0000));
        directed.push_back(row(REQ_ADD_EDGE, 16'h0000, 16'h0001, 16'h0000));
        directed.push_back(row(REQ_ADD_EDGE, 16'h0002, 16'h0000, 16'h0000));
        directed.push_back(row(REQ_ADD_EDGE, 16'h0001, 16'h0001, 16'h0000));
        directed.push_back(row(REQ_START, 16'hFFFF, 16'hFFFF, 16'h0000));
        repeat (6) directed.push_back(row(REQ_ADVANCE, '0, '0, '0));
        directed.push_back(row(REQ_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        directed.push_back(row(REQ_ADVANCE, '0, '0, '0));
        directed.push_back(row(REQ_START, '0, '0, 16'hFFFF));
        directed.push_back(checked_row(REQ_ADVANCE, '0,
                                       mk_rec(KIND_HEADER, 1, 1, 16'hFFFF, 0, 1)));
        directed.push_back(checked_row(REQ_ADVANCE, '0, mk_rec(KIND_DONE, 1, 2, '0, 0, 1)));
        foreach (directed[i])
            send_req(directed[i].req, directed[i].src, directed[i].dst, directed[i].start,
                     directed[i].fixed, directed[i].want);

        // A depth limit of zero or one stops the walk at once.
        write_limit(8'd0);
        req(REQ_CLEAR, '0, '0, '0);
        req(REQ_ADD_EDGE, 16'd0, 16'd1, '0);
        req(REQ_START, '0, '0, 16'd0);
        req(REQ_ADVANCE, '0, '0, '0);
        write_limit(8'd1);
        req(REQ_ADVANCE, '0, '0, '0);

        // A star wider than the visited list drops children and flags overflow.
        write_limit(8'd255);
        req(REQ_CLEAR, '0, '0, '0);
        for (int i = 1; i <= 70; i++)
            req(REQ_ADD_EDGE, 16'd0, 16'(i), '0);
        req(REQ_START, '0, '0, 16'd0);
        repeat (3) req(REQ_ADVANCE, '0, '0, '0);

        // Overfill the edge store; the extra edges must be dropped.
        wait_drained();
        req(REQ_CLEAR, '0, '0, '0);
        for (int i = 0; i < EDGE_SLOTS + 6; i++)
            req(REQ_ADD_EDGE, 16'($urandom_range(3)), 16'($urandom_range(20)), '0);
        req(REQ_START, '0, '0, 16'd0);
        repeat (4) req(REQ_ADVANCE, '0, '0, '0);
        wait_drained();
        req(REQ_CLEAR, '0, '0, '0);

        limits = '{255, 2, 3, $urandom_range(4, 254)};
        items_sent = 0;
        for (int p = 0; p < 4; p++)
        begin
            write_limit(8'(limits[p]));
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 46; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 46; end
                default: begin idle_pct = 12; stall_pct = 12; end
            endcase
            target = (p + 1) * 65;
            while (items_sent < target)
                run_sequence();
        end

        wait_drained();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
`default_nettype wire
